[rtl/core/utf8_codepoint_decoder_defines.svh]
// Assertion macros shared by the UTF-8 code point decoder.
// No dependencies; files that check behavior include this header.
`ifndef UTF8_CODEPOINT_DECODER_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define U8CD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8cd check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define U8CD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8cd check failed");

`endif

[rtl/core/u8cd_pkg.sv]
// Shared types and constants of the UTF-8 code point decoder.
// No dependencies; used by all decoder modules.
package u8cd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_2BYTE_CP   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3BYTE_CP   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE_CP   = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO_CP     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI_CP     = 21'h00DFFF;

  // Continuation counts of the lead byte classes
  localparam logic [1:0] CONT_NONE = 2'd0;
  localparam logic [1:0] CONT_ONE  = 2'd1;
  localparam logic [1:0] CONT_TWO  = 2'd2;
  localparam logic [1:0] CONT_THREE = 2'd3;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One queued transaction: an optional leading U+FFFD, then the main result
  typedef struct packed {
    logic            has_pre;
    logic [CP_W-1:0] cp;
    logic            rep;
  } u8cd_entry_t;

endpackage

[rtl/core/u8cd_front.sv]
// Front part of the UTF-8 decoder: accepts bytes, tracks sequence state and
// classifies each byte into a queue entry. Depends on u8cd_pkg.
module u8cd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [7:0]            text_byte,
  input  logic [1:0]            bytes_after,
  input  logic                  queue_full,
  output logic                  push,
  output u8cd_pkg::u8cd_entry_t push_entry
);
  import u8cd_pkg::*;

  logic [CP_W-1:0] acc, acc_next;
  logic [1:0]      left, left_next;
  logic [1:0]      seq_len, seq_len_next;
  logic            discard, discard_next;
  logic            accept;

  // Lead byte classification
  logic            st_ascii;
  logic            st_multi;
  logic [1:0]      st_count;
  logic [CP_W-1:0] st_bits;
  logic            st_emit;
  logic [CP_W-1:0] st_cp;
  logic            st_rep;
  logic            st_short;

  // Continuation path
  logic            is_cont;
  logic [CP_W-1:0] cont_v;
  logic            overlong;
  logic            bad;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    st_ascii = 1'b0;
    st_multi = 1'b1;
    st_count = CONT_NONE;
    st_bits  = '0;
    if (!text_byte[7]) begin
      st_ascii = 1'b1;
      st_multi = 1'b0;
    end else if (text_byte[7:5] == 3'b110) begin
      st_count = CONT_ONE;
      st_bits  = CP_W'(text_byte[4:0]);
    end else if (text_byte[7:4] == 4'b1110) begin
      st_count = CONT_TWO;
      st_bits  = CP_W'(text_byte[3:0]);
    end else if (text_byte[7:3] == 5'b11110) begin
      st_count = CONT_THREE;
      st_bits  = CP_W'(text_byte[2:0]);
    end else begin
      st_multi = 1'b0;
    end
    // truncated sequence: not enough bytes left in the text
    st_short = st_multi && (st_count > bytes_after);
    st_emit  = !st_multi || st_short;
    st_cp    = st_ascii ? CP_W'(text_byte) : REPLACEMENT_CP;
    st_rep   = !st_ascii;
  end

  // Continuation byte accumulate and final range checks
  always_comb begin
    is_cont  = (text_byte[7:6] == 2'b10);
    cont_v   = {acc[CP_W-7:0], text_byte[5:0]};
    overlong = ((seq_len == CONT_ONE)   && (cont_v < MIN_2BYTE_CP)) ||
               ((seq_len == CONT_TWO)   && (cont_v < MIN_3BYTE_CP)) ||
               ((seq_len == CONT_THREE) && (cont_v < MIN_4BYTE_CP));
    bad      = overlong || (cont_v > MAX_CP) ||
               ((cont_v >= SURR_LO_CP) && (cont_v <= SURR_HI_CP));
  end

  // Next state and queue entry
  always_comb begin
    acc_next     = acc;
    left_next    = left;
    seq_len_next = seq_len;
    discard_next = discard;
    push         = 1'b0;
    push_entry   = '{has_pre: 1'b0, cp: REPLACEMENT_CP, rep: 1'b1};
    if (accept) begin
      if (discard) begin
        if (bytes_after == 2'd0) begin
          discard_next = 1'b0;
        end
      end else if (left != CONT_NONE && is_cont) begin
        left_next = left - 2'd1;
        if (left == CONT_ONE) begin
          acc_next     = '0;
          seq_len_next = CONT_NONE;
          push         = 1'b1;
          push_entry.cp  = bad ? REPLACEMENT_CP : cont_v;
          push_entry.rep = bad;
        end else begin
          acc_next = cont_v;
        end
      end else begin
        // broken sequence drops the state, then the byte is decoded as a lead
        if (left != CONT_NONE) begin
          acc_next     = '0;
          left_next    = CONT_NONE;
          seq_len_next = CONT_NONE;
        end
        if (st_emit) begin
          push           = 1'b1;
          push_entry.has_pre = (left != CONT_NONE);
          push_entry.cp  = st_cp;
          push_entry.rep = st_rep;
          if (st_short) begin
            discard_next = (bytes_after != 2'd0);
          end
        end else begin
          acc_next     = st_bits;
          left_next    = st_count;
          seq_len_next = st_count;
          // lone U+FFFD for the broken sequence
          push         = (left != CONT_NONE);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      left    <= CONT_NONE;
      seq_len <= CONT_NONE;
      discard <= 1'b0;
    end else begin
      acc     <= acc_next;
      left    <= left_next;
      seq_len <= seq_len_next;
      discard <= discard_next;
    end
  end

endmodule

[rtl/core/u8cd_fifo.sv]
// Short queue of classified entries between decoder front and back.
// Depends on u8cd_pkg for the entry type.
module u8cd_fifo #(
  parameter int unsigned DEPTH = u8cd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8cd_pkg::u8cd_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output u8cd_pkg::u8cd_entry_t pop_entry,
  output logic                  empty
);
  import u8cd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8cd_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/u8cd_back.sv]
// Back part of the UTF-8 decoder: holds one queue entry in an output
// register and expands it into one or two results. Depends on u8cd_pkg.
module u8cd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  queue_empty,
  input  u8cd_pkg::u8cd_entry_t queue_entry,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [20:0]           code_point,
  output logic                  is_replacement,
  output logic                  run_last
);
  import u8cd_pkg::*;

  u8cd_entry_t cur;
  logic        cur_valid;
  logic        pre_done;
  logic        in_pre;
  logic        taken;
  logic        load;

  // Leading U+FFFD is shown first when the entry carries one
  assign in_pre         = cur.has_pre && !pre_done;
  assign result_valid   = cur_valid;
  assign code_point     = in_pre ? REPLACEMENT_CP : cur.cp;
  assign is_replacement = in_pre ? 1'b1 : cur.rep;
  assign run_last       = !in_pre;

  assign taken = cur_valid && !result_stall;
  assign load  = !cur_valid || (taken && !in_pre);
  assign pop   = load && !queue_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= queue_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pre_done  <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= !queue_empty;
        pre_done  <= 1'b0;
      end else if (taken && in_pre) begin
        pre_done <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/utf8_codepoint_decoder.sv]
// UTF-8 to code point decoder: one byte per transaction in, code points out.
// Takes the byte channel on byte_valid/byte_stall with text_byte and
// bytes_after (bytes of the text still to come, saturated at 3); gives
// results on result_valid/result_stall with code_point, is_replacement
// and run_last (set on the last result that a byte causes).
// A result is registered in the queue and then in the output register
// before it shows on result_valid.
// Throughput: one byte per cycle unless byte_stall is high. A byte that
// breaks a sequence and gives two results holds the output register for
// both of them; the queue between front and back absorbs that, and
// byte_stall rises only once the queue is full. Bytes inside a sequence,
// or swallowed after a truncated lead, give no result.
// When result_stall is high the current result holds and the queue fills;
// byte_stall then rises until the queue drains.
// Reset (rst, synchronous) clears the sequence state, empties the queue
// and drops any pending result.
// Depends on u8cd_pkg, u8cd_front, u8cd_fifo, u8cd_back and the defines.
`include "utf8_codepoint_decoder_defines.svh"

module utf8_codepoint_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8cd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  text_byte,
  input  logic [1:0]  bytes_after,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [20:0] code_point,
  output logic        is_replacement,
  output logic        run_last
);
  import u8cd_pkg::*;

  logic        queue_full, queue_empty;
  logic        push, pop;
  u8cd_entry_t push_entry, pop_entry;

  u8cd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .text_byte  (text_byte),
    .bytes_after(bytes_after),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8cd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (queue_empty)
  );

  u8cd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .queue_entry   (pop_entry),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .code_point    (code_point),
    .is_replacement(is_replacement),
    .run_last      (run_last)
  );

  // Checks
  `U8CD_ASSERT_IMP(a_rep_value, result_valid && is_replacement, code_point == REPLACEMENT_CP)
  `U8CD_ASSERT_IMP(a_first_is_rep, result_valid && !run_last, is_replacement)
  `U8CD_ASSERT_IMP(a_scalar_range, result_valid && !is_replacement,
    (code_point <= MAX_CP) && ((code_point < SURR_LO_CP) || (code_point > SURR_HI_CP)))
  `U8CD_ASSERT_NEXT(a_pair_follows, result_valid && !result_stall && !run_last,
    result_valid && run_last)

endmodule
